### rtl/core/disk_request_scheduler_assert.svh
// Assertion macros shared by the checker of the disk request scheduler.
// Depends on nothing; the including file supplies the clock and reset names.
`ifndef DISK_REQUEST_SCHEDULER_ASSERT_SVH
`define DISK_REQUEST_SCHEDULER_ASSERT_SVH

// Same-cycle implication.
`define DRS_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("disk request scheduler check failed");

// Next-cycle implication.
`define DRS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("disk request scheduler check failed");

`endif

### rtl/core/dsched_pkg.sv
// Shared types, codes and constants of the disk request scheduler.
// Used by every RTL file of the block but dsched_ram; depends on nothing.
package dsched_pkg;

   localparam int MAX_REQUESTS_DEF = 16;
   localparam int CYL_W = 16;
   localparam int TOT_W = 21;
   localparam int POL_W = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic [POL_W-1:0] POL_FCFS  = 3'd0;
   localparam logic [POL_W-1:0] POL_SSTF  = 3'd1;
   localparam logic [POL_W-1:0] POL_SCAN  = 3'd2;
   localparam logic [POL_W-1:0] POL_CSCAN = 3'd3;
   localparam logic [POL_W-1:0] POL_CLOOK = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_POLICY  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_CYL = 2'd1;

   localparam logic [CYL_W-1:0] MAX_CYL_RESET = 16'hFFFF;

   typedef struct packed {
      logic [CYL_W-1:0] cylinder;
      logic [CYL_W-1:0] start_head;
      logic             sweep_up;
      logic             last;
   } req_type;

   typedef struct packed {
      logic [CYL_W-1:0] visit_cylinder;
      logic [CYL_W-1:0] move_distance;
      logic [TOT_W-1:0] total_movement;
      logic             rejected;
      logic             run_end;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WAIT,
      ST_DECIDE,
      ST_BND1,
      ST_BND2,
      ST_FLUSH,
      ST_REJECT
   } state_type;

   typedef enum logic [1:0] {
      GRP_ANY,
      GRP_UPPER,
      GRP_LOWER
   } grp_type;

   typedef enum logic [1:0] {
      ORD_FIRST,
      ORD_NEAR,
      ORD_ASC,
      ORD_DESC
   } ord_type;

   typedef enum logic [1:0] {
      EM_BEST,
      EM_ZERO,
      EM_MAX
   } emit_sel_type;

   typedef struct packed {
      logic         load;
      logic         scan_rd;
      logic         scan_first;
      logic         emit;
      emit_sel_type emit_sel;
      logic         flush;
      logic         reject;
      grp_type      grp;
      ord_type      ord;
   } cmd_type;

   typedef struct packed {
      logic             found;
      logic             other;
      logic             bad;
      logic             head_at_max;
      logic             head_at_zero;
      logic             dir_up;
      logic [POL_W-1:0] policy;
   } status_type;

endpackage

### rtl/core/disk_request_scheduler.sv
// Disk request scheduler. A request not marked last is taken and gives no result. On the last
// one, busy stays high through a selection pass over the stored requests per result and one
// that finds none left, per phase under the sweep policies, with the end-cylinder moves between
// under SCAN and C-SCAN; a rejected batch takes one reject state. The final result strobes in
// the first idle cycle, where the next request may already be taken; the receiver cannot stall.
// Synchronous active-high reset clears the batch, sets policy FCFS and max_cylinder 65535.
module disk_request_scheduler #(
   parameter int MAX_REQUESTS = dsched_pkg::MAX_REQUESTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel: accepted when start is high and busy is low.
   input  logic                             start,
   output logic                             busy,
   input  dsched_pkg::req_type              req_data,
   // Result channel: one strobe per result.
   output logic                             rsp_valid,
   output dsched_pkg::rsp_type              rsp_data,
   // Register writes.
   input  logic                             csr_we,
   input  logic [dsched_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dsched_pkg::CYL_W-1:0]     csr_wdata
);

   localparam int IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CW = $clog2(MAX_REQUESTS + 1);

   dsched_pkg::cmd_type    cmd;
   dsched_pkg::status_type status;
   logic [IW-1:0]          scan_addr;
   logic [CW-1:0]          count;

   // The controller walks the store once per selection pass. Each pass selects at most one
   // unvisited entry by the rule of the current phase: first in arrival order for FCFS,
   // nearest to the head for SSTF, and for the sweep policies the next entry in sweep order
   // within the group above or below the starting head. Between the two sweep phases it
   // inserts the moves to the end cylinders under SCAN and C-SCAN.
   dsched_ctrl #(
      .MAX_REQUESTS(MAX_REQUESTS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_last (req_data.last),
      .busy     (busy),
      .cmd      (cmd),
      .scan_addr(scan_addr),
      .status   (status),
      .count    (count)
   );

   // The datapath holds the store, the per-entry visited bits and the running totals.
   // A result is held back one move so that the final one can carry run_end.
   dsched_dp #(
      .MAX_REQUESTS(MAX_REQUESTS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .scan_addr(scan_addr),
      .req_data (req_data),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .status   (status),
      .count    (count),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

endmodule

### rtl/core/dsched_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module dsched_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/dsched_ctrl.sv
// Controller of the disk request scheduler: batch loading and the selection passes.
// Depends on dsched_pkg.
module dsched_ctrl #(
   parameter int MAX_REQUESTS = dsched_pkg::MAX_REQUESTS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       req_last,
   output logic                       busy,
   output dsched_pkg::cmd_type        cmd,
   output logic [(MAX_REQUESTS > 1 ? $clog2(MAX_REQUESTS) : 1)-1:0] scan_addr,
   input  dsched_pkg::status_type     status,
   input  logic [$clog2(MAX_REQUESTS + 1)-1:0] count
);

   localparam int IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CW = $clog2(MAX_REQUESTS + 1);

   dsched_pkg::state_type state_ff, state_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic                  phase_b_ff, phase_b_in;
   logic                  pol_sort;

   assign pol_sort = status.policy inside {dsched_pkg::POL_SCAN, dsched_pkg::POL_CSCAN,
                                           dsched_pkg::POL_CLOOK};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= dsched_pkg::ST_IDLE;
         idx_ff     <= '0;
         phase_b_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         phase_b_ff <= phase_b_in;
      end
   end

   // Next state.
   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      phase_b_in = phase_b_ff;
      case (state_ff)
         dsched_pkg::ST_IDLE: begin
            if (start && req_last) begin
               idx_in     = '0;
               phase_b_in = 1'b0;
               state_in   = status.bad ? dsched_pkg::ST_REJECT : dsched_pkg::ST_SCAN;
            end
         end
         dsched_pkg::ST_SCAN: begin
            idx_in = idx_ff + CW'(1);
            if (idx_ff + CW'(1) == count) begin
               state_in = dsched_pkg::ST_WAIT;
            end
         end
         dsched_pkg::ST_WAIT: begin
            state_in = dsched_pkg::ST_DECIDE;
         end
         dsched_pkg::ST_DECIDE: begin
            idx_in = '0;
            if (status.found) begin
               state_in = dsched_pkg::ST_SCAN;
            end else if (!pol_sort || phase_b_ff) begin
               state_in = dsched_pkg::ST_FLUSH;
            end else begin
               phase_b_in = 1'b1;
               state_in   = dsched_pkg::ST_BND1;
            end
         end
         dsched_pkg::ST_BND1: begin
            if (status.policy == dsched_pkg::POL_CSCAN) begin
               state_in = status.other ? dsched_pkg::ST_BND2 : dsched_pkg::ST_FLUSH;
            end else begin
               state_in = dsched_pkg::ST_SCAN;
            end
         end
         dsched_pkg::ST_BND2: begin
            state_in = dsched_pkg::ST_SCAN;
         end
         dsched_pkg::ST_FLUSH: begin
            state_in = dsched_pkg::ST_IDLE;
         end
         dsched_pkg::ST_REJECT: begin
            state_in = dsched_pkg::ST_IDLE;
         end
         default: begin
            state_in = dsched_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      cmd          = '0;
      cmd.emit_sel = dsched_pkg::EM_BEST;
      busy         = (state_ff != dsched_pkg::ST_IDLE);
      scan_addr    = idx_ff[IW-1:0];

      // Selection rule of the current pass.
      if (status.policy == dsched_pkg::POL_SSTF) begin
         cmd.grp = dsched_pkg::GRP_ANY;
         cmd.ord = dsched_pkg::ORD_NEAR;
      end else if (!pol_sort) begin
         cmd.grp = dsched_pkg::GRP_ANY;
         cmd.ord = dsched_pkg::ORD_FIRST;
      end else if (!phase_b_ff) begin
         cmd.grp = status.dir_up ? dsched_pkg::GRP_UPPER : dsched_pkg::GRP_LOWER;
         cmd.ord = status.dir_up ? dsched_pkg::ORD_ASC : dsched_pkg::ORD_DESC;
      end else if (status.policy == dsched_pkg::POL_SCAN) begin
         cmd.grp = status.dir_up ? dsched_pkg::GRP_LOWER : dsched_pkg::GRP_UPPER;
         cmd.ord = status.dir_up ? dsched_pkg::ORD_DESC : dsched_pkg::ORD_ASC;
      end else begin
         cmd.grp = status.dir_up ? dsched_pkg::GRP_LOWER : dsched_pkg::GRP_UPPER;
         cmd.ord = status.dir_up ? dsched_pkg::ORD_ASC : dsched_pkg::ORD_DESC;
      end

      case (state_ff)
         dsched_pkg::ST_IDLE: begin
            cmd.load = start;
         end
         dsched_pkg::ST_SCAN: begin
            cmd.scan_rd    = 1'b1;
            cmd.scan_first = (idx_ff == '0);
         end
         dsched_pkg::ST_DECIDE: begin
            cmd.emit = status.found;
         end
         dsched_pkg::ST_BND1: begin
            if (status.policy == dsched_pkg::POL_SCAN ||
                (status.policy == dsched_pkg::POL_CSCAN && status.other)) begin
               if (status.dir_up) begin
                  cmd.emit     = !status.head_at_max;
                  cmd.emit_sel = dsched_pkg::EM_MAX;
               end else begin
                  cmd.emit     = !status.head_at_zero;
                  cmd.emit_sel = dsched_pkg::EM_ZERO;
               end
            end
         end
         dsched_pkg::ST_BND2: begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = status.dir_up ? dsched_pkg::EM_ZERO : dsched_pkg::EM_MAX;
         end
         dsched_pkg::ST_FLUSH: begin
            cmd.flush = 1'b1;
         end
         dsched_pkg::ST_REJECT: begin
            cmd.reject = 1'b1;
         end
         default: begin
            cmd.flush = 1'b0;
         end
      endcase
   end

endmodule

### rtl/core/dsched_dp.sv
// Datapath of the disk request scheduler: request store, selection unit, result registers.
// Depends on dsched_pkg and dsched_ram.
module dsched_dp #(
   parameter int MAX_REQUESTS = dsched_pkg::MAX_REQUESTS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  dsched_pkg::cmd_type                    cmd,
   input  logic [(MAX_REQUESTS > 1 ? $clog2(MAX_REQUESTS) : 1)-1:0] scan_addr,
   input  dsched_pkg::req_type                    req_data,
   input  logic                                   csr_we,
   input  logic [dsched_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dsched_pkg::CYL_W-1:0]           csr_wdata,
   output dsched_pkg::status_type                 status,
   output logic [$clog2(MAX_REQUESTS + 1)-1:0]    count,
   output logic                                   rsp_valid,
   output dsched_pkg::rsp_type                    rsp_data
);

   localparam int IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CW = $clog2(MAX_REQUESTS + 1);
   localparam int YW = dsched_pkg::CYL_W;
   localparam int TW = dsched_pkg::TOT_W;

   logic [dsched_pkg::POL_W-1:0] policy_ff, policy_in;
   logic [YW-1:0]     max_cyl_ff, max_cyl_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic              rng_ff, rng_in;
   logic [YW-1:0]     head0_ff, head0_in;
   logic              up_ff, up_in;
   logic [YW-1:0]     head_pos_ff, head_pos_in;
   logic [TW-1:0]     total_ff, total_in;
   logic [MAX_REQUESTS-1:0] used_ff, used_in;
   logic              rd_v_ff, rd_v_in;
   logic [IW-1:0]     rd_idx_ff, rd_idx_in;
   logic              found_ff, found_in;
   logic              other_ff, other_in;
   logic [YW-1:0]     best_v_ff, best_v_in;
   logic [YW-1:0]     best_d_ff, best_d_in;
   logic [IW-1:0]     best_idx_ff, best_idx_in;
   logic              pend_v_ff, pend_v_in;
   dsched_pkg::rsp_type pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   dsched_pkg::rsp_type rsp_ff, rsp_in;

   logic              full;
   logic              ram_we;
   logic [YW-1:0]     rdata;
   logic              v_up, unused, grp_ok, oth, better;
   logic [YW-1:0]     d;
   logic [YW-1:0]     em_v, em_d;
   logic [TW-1:0]     em_tot;

   assign full   = (count_ff == CW'(MAX_REQUESTS));
   assign ram_we = cmd.load && !full;

   dsched_ram #(
      .WIDTH(YW),
      .DEPTH(MAX_REQUESTS)
   ) u_store (
      .clock(clock),
      .we   (ram_we),
      .waddr(count_ff[IW-1:0]),
      .wdata(req_data.cylinder),
      .raddr(scan_addr),
      .rdata(rdata)
   );

   // Candidate evaluation for the entry read in the previous cycle.
   always_comb begin
      v_up   = (rdata >= head0_ff);
      unused = !used_ff[rd_idx_ff];
      d      = (head_pos_ff > rdata) ? head_pos_ff - rdata : rdata - head_pos_ff;
      case (cmd.grp)
         dsched_pkg::GRP_ANY: begin
            grp_ok = 1'b1;
            oth    = 1'b0;
         end
         dsched_pkg::GRP_UPPER: begin
            grp_ok = v_up;
            oth    = !v_up;
         end
         dsched_pkg::GRP_LOWER: begin
            grp_ok = !v_up;
            oth    = v_up;
         end
         default: begin
            grp_ok = 1'b0;
            oth    = 1'b0;
         end
      endcase
      case (cmd.ord)
         dsched_pkg::ORD_FIRST: better = !found_ff;
         dsched_pkg::ORD_NEAR:  better = !found_ff || (d < best_d_ff);
         dsched_pkg::ORD_ASC:   better = !found_ff || (rdata < best_v_ff);
         dsched_pkg::ORD_DESC:  better = !found_ff || (rdata > best_v_ff);
         default:               better = 1'b0;
      endcase
   end

   // Move taken on an emit.
   always_comb begin
      case (cmd.emit_sel)
         dsched_pkg::EM_BEST: em_v = best_v_ff;
         dsched_pkg::EM_ZERO: em_v = '0;
         dsched_pkg::EM_MAX:  em_v = max_cyl_ff;
         default:             em_v = best_v_ff;
      endcase
      em_d   = (head_pos_ff > em_v) ? head_pos_ff - em_v : em_v - head_pos_ff;
      em_tot = total_ff + TW'(em_d);
   end

   always_comb begin
      policy_in    = policy_ff;
      max_cyl_in   = max_cyl_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      rng_in       = rng_ff;
      head0_in     = head0_ff;
      up_in        = up_ff;
      head_pos_in  = head_pos_ff;
      total_in     = total_ff;
      used_in      = used_ff;
      rd_v_in      = cmd.scan_rd;
      rd_idx_in    = scan_addr;
      found_in     = found_ff;
      other_in     = other_ff;
      best_v_in    = best_v_ff;
      best_d_in    = best_d_ff;
      best_idx_in  = best_idx_ff;
      pend_v_in    = pend_v_ff;
      pend_in      = pend_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = pend_ff;

      if (csr_we) begin
         case (csr_index)
            dsched_pkg::CSR_POLICY:  policy_in  = csr_wdata[dsched_pkg::POL_W-1:0];
            dsched_pkg::CSR_MAX_CYL: max_cyl_in = csr_wdata;
            default:                 policy_in  = policy_ff;
         endcase
      end

      if (cmd.load) begin
         if (req_data.cylinder > max_cyl_ff) begin
            rng_in = 1'b1;
         end
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + CW'(1);
         end
         if (req_data.last) begin
            head0_in    = req_data.start_head;
            up_in       = req_data.sweep_up;
            head_pos_in = req_data.start_head;
            total_in    = '0;
            used_in     = '0;
            pend_v_in   = 1'b0;
         end
      end

      if (cmd.scan_first) begin
         found_in = 1'b0;
         other_in = 1'b0;
      end else if (rd_v_ff) begin
         if (unused && oth) begin
            other_in = 1'b1;
         end
         if (unused && grp_ok && better) begin
            found_in    = 1'b1;
            best_v_in   = rdata;
            best_d_in   = d;
            best_idx_in = rd_idx_ff;
         end
      end

      if (cmd.emit) begin
         if (cmd.emit_sel == dsched_pkg::EM_BEST) begin
            used_in[best_idx_ff] = 1'b1;
         end
         head_pos_in  = em_v;
         total_in     = em_tot;
         rsp_valid_in = pend_v_ff;
         rsp_in.run_end = 1'b0;
         pend_v_in    = 1'b1;
         pend_in      = '{visit_cylinder: em_v, move_distance: em_d, total_movement: em_tot,
                          rejected: 1'b0, run_end: 1'b0};
      end

      if (cmd.flush) begin
         rsp_valid_in   = 1'b1;
         rsp_in.run_end = 1'b1;
         pend_v_in      = 1'b0;
      end

      if (cmd.reject) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '{visit_cylinder: '0, move_distance: '0, total_movement: '0,
                          rejected: 1'b1, run_end: 1'b1};
      end

      if (cmd.flush || cmd.reject) begin
         count_in = '0;
         ovf_in   = 1'b0;
         rng_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff    <= dsched_pkg::POL_FCFS;
         max_cyl_ff   <= dsched_pkg::MAX_CYL_RESET;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rng_ff       <= 1'b0;
         rd_v_ff      <= 1'b0;
         found_ff     <= 1'b0;
         other_ff     <= 1'b0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         policy_ff    <= policy_in;
         max_cyl_ff   <= max_cyl_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rng_ff       <= rng_in;
         rd_v_ff      <= rd_v_in;
         found_ff     <= found_in;
         other_ff     <= other_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head0_ff    <= head0_in;
      up_ff       <= up_in;
      head_pos_ff <= head_pos_in;
      total_ff    <= total_in;
      used_ff     <= used_in;
      rd_idx_ff   <= rd_idx_in;
      best_v_ff   <= best_v_in;
      best_d_ff   <= best_d_in;
      best_idx_ff <= best_idx_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      status.found        = found_ff;
      status.other        = other_ff;
      status.bad          = ovf_ff || rng_ff || full ||
                            (req_data.cylinder > max_cyl_ff) ||
                            (req_data.start_head > max_cyl_ff);
      status.head_at_max  = (head_pos_ff == max_cyl_ff);
      status.head_at_zero = (head_pos_ff == '0);
      status.dir_up       = up_ff;
      status.policy       = policy_ff;
   end

   assign count     = count_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/core/dsched_checker.sv
// Port-level checks of the disk request scheduler, bound to the top level.
// Depends on dsched_pkg and disk_request_scheduler_assert.svh.
`include "disk_request_scheduler_assert.svh"

module dsched_checker (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input dsched_pkg::req_type req_data,
   input logic                rsp_valid,
   input dsched_pkg::rsp_type rsp_data
);

   `DRS_ASSERT_NEXT(a_plain_req_no_rsp, clock, reset, start && !busy && !req_data.last, !rsp_valid)
   `DRS_ASSERT_NOW(a_reject_ends, clock, reset, rsp_valid && rsp_data.rejected, rsp_data.run_end && rsp_data.total_movement == '0)
   `DRS_ASSERT_NEXT(a_more_follows, clock, reset, rsp_valid && !rsp_data.run_end, busy)
   `DRS_ASSERT_NOW(a_end_idle, clock, reset, rsp_valid && rsp_data.run_end, !busy)

endmodule

bind disk_request_scheduler dsched_checker u_dsched_checker (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_data (rsp_data)
);
